// ===== hw/rtl/cvc_pkg.sv =====
// Shared types, constants and colour functions of the bitmap and character
// video compositor. Depends on nothing; the compositor, pixel stage, checker
// and testbench refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cvc_pkg;

	localparam int BITMAP_DEPTH = 8192;
	localparam int CHAR_DEPTH   = 4096;
	localparam int PEN_DEPTH    = BITMAP_DEPTH / 8;
	localparam int BM_AW        = $clog2(BITMAP_DEPTH);
	localparam int CHAR_AW      = $clog2(CHAR_DEPTH);
	localparam int PEN_AW       = $clog2(PEN_DEPTH);

	// Background mix constants
	localparam logic [7:0] BG_RED_BASE = 8'h18;
	localparam logic [7:0] BG_GB_BASE  = 8'h24;
	localparam logic [7:0] BG_MIX_BASE = 8'h31;

	// Upper two bits of a character RAM address per plane region
	localparam logic [1:0] CHAR_CODE_AREA = 2'b00; // codes, 0x000
	localparam logic [1:0] CHAR_PLANE_A   = 2'b01; // 0x400
	localparam logic [1:0] CHAR_PLANE_B2  = 2'b11; // 0xC00, two-plane characters
	localparam logic [1:0] CHAR_PLANE_B1  = 2'b10; // 0x800, single-plane characters

	localparam logic [7:0] COL3_STEP = 8'd36;
	localparam logic [7:0] COL2_STEP = 8'd85;

	typedef enum logic [2:0] {
		CMD_BITMAP = 3'd0,
		CMD_CHAR   = 3'd1,
		CMD_PROM   = 3'd2,
		CMD_PEN    = 3'd3,
		CMD_FLIP   = 3'd4,
		CMD_RENDER = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// Everything the pixel stage needs for one render
	typedef struct packed {
		logic [7:0]      bits;
		logic [7:0]      pa;
		logic [7:0]      pb;
		logic [2:0]      pen;
		logic            prio;
		logic [2:0][7:0] prom;   // entries for character pens 1, 2, 3
		logic [4:0]      col;
		logic [7:0]      row;
		logic            normal;
		logic            layout;
	} render_job_t;

	function automatic rgb_t bg_rgb(input logic layout);
		rgb_t       c;
		logic [7:0] mix;
		mix = BG_MIX_BASE + {7'd0, layout};
		c.r = BG_RED_BASE ^ {mix[6:0], 1'b0};
		c.g = BG_GB_BASE ^ mix;
		c.b = BG_GB_BASE ^ {1'b0, mix[7:1]};
		return c;
	endfunction

	function automatic rgb_t prom_rgb(input logic [7:0] v);
		rgb_t       c;
		logic [2:0] rb;
		logic [2:0] gb;
		logic [1:0] bb;
		rb = {v[4], v[6], v[2]};
		gb = {v[5], v[3], v[1]};
		bb = {v[7], v[0]};
		c.r = 8'({5'd0, rb} * COL3_STEP);
		c.g = 8'({5'd0, gb} * COL3_STEP);
		c.b = 8'({6'd0, bb} * COL2_STEP);
		return c;
	endfunction

	function automatic rgb_t pen_rgb(input logic [2:0] pen);
		rgb_t c;
		c.r = pen[2] ? 8'hFF : 8'h00;
		c.g = pen[1] ? 8'hFF : 8'h00;
		c.b = pen[0] ? 8'hFF : 8'h00;
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module cvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cvc_mod_lane.sv =====
// Bit-serial remainder lane: reduces a 9-bit colour PROM index modulo the
// PROM depth, one dividend bit per cycle. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module cvc_mod_lane #(
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [8:0]    value,
	output logic      [AW-1:0] rem,
	output logic               done
);

	logic [8:0] val_q;
	logic [8:0] r_q;     // partial remainder, always below DEPTH
	logic [3:0] cnt_q;
	logic [9:0] trial;

	assign trial = {r_q, val_q[8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 4'd9;
		end else if (cnt_q != 4'd0) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			r_q   <= '0;
		end else if (cnt_q != 4'd0) begin
			val_q <= {val_q[7:0], 1'b0};
			r_q   <= (trial >= 10'(DEPTH)) ? 9'(trial - 10'(DEPTH)) : trial[8:0];
		end
	end

	assign rem  = r_q[AW-1:0];
	assign done = (cnt_q == 4'd0);

endmodule

`default_nettype wire

// ===== hw/rtl/cvc_pixel_serial.sv =====
// Pixel stage: shifts bitmap and plane bits out one per pixel, mixes the
// colour and holds the result in the output register. Depends on cvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvc_pixel_serial #(
	parameter int VISIBLE_WIDTH  = 256,
	parameter int VISIBLE_HEIGHT = 224
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire cvc_pkg::render_job_t job,
	output logic                      busy,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [7:0]           pixel_x,
	output logic      [7:0]           pixel_y,
	output logic      [7:0]           red,
	output logic      [7:0]           green,
	output logic      [7:0]           blue,
	output logic                      visible,
	output logic                      last
);

	cvc_pkg::render_job_t job_q;
	logic                 busy_q;
	logic                 out_valid_q;
	logic [2:0]           k_q;
	logic                 advance;

	logic [7:0] pixel_x_q, pixel_y_q, red_q, green_q, blue_q;
	logic       visible_q, last_q;

	logic [7:0]    x;
	logic [9:0]    mx, my;
	logic          on;
	logic [1:0]    cp;
	cvc_pkg::rgb_t colour;
	logic [7:0]    dx, dy;
	logic          vis;

	assign advance = busy_q && (!out_valid_q || out_ready);

	always_comb begin
		x   = {job_q.col, k_q};
		mx  = 10'(VISIBLE_WIDTH - 1) - {2'b00, x};
		my  = 10'(VISIBLE_HEIGHT - 1) - {2'b00, job_q.row};
		dx  = job_q.normal ? x : mx[7:0];
		dy  = job_q.normal ? job_q.row : my[7:0];
		// A mirrored coordinate that does not go negative is always on screen
		vis = (job_q.normal ? ({1'b0, x} < 9'(VISIBLE_WIDTH)) : !mx[9])
		   && (job_q.normal ? ({1'b0, job_q.row} < 9'(VISIBLE_HEIGHT)) : !my[9]);

		on = job_q.bits[7];
		cp = {job_q.pb[7], job_q.pa[7]};
		if (cp == 2'd0 || (on && job_q.prio)) begin
			colour = on ? cvc_pkg::pen_rgb(job_q.pen) : cvc_pkg::bg_rgb(job_q.layout);
		end else begin
			case (cp)
				2'd1:    colour = cvc_pkg::prom_rgb(job_q.prom[0]);
				2'd2:    colour = cvc_pkg::prom_rgb(job_q.prom[1]);
				default: colour = cvc_pkg::prom_rgb(job_q.prom[2]);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (advance) begin
				k_q <= k_q + 3'd1;
				if (k_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= job;
		end else if (advance) begin
			job_q.bits <= {job_q.bits[6:0], 1'b0};
			job_q.pa   <= {job_q.pa[6:0], 1'b0};
			job_q.pb   <= {job_q.pb[6:0], 1'b0};
		end
		if (advance) begin
			pixel_x_q <= dx;
			pixel_y_q <= dy;
			red_q     <= colour.r;
			green_q   <= colour.g;
			blue_q    <= colour.b;
			visible_q <= vis;
			last_q    <= (k_q == 3'd7);
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign visible   = visible_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_char_video_compositor.sv =====
// Bitmap and character video compositor: stores, command decode, render
// sequencer. Depends on cvc_pkg, cvc_ram, cvc_mod_lane and cvc_pixel_serial.
// Store writes and pen/flip settings take effect as the item is accepted. A
// render does the store reads, one or two plane reads, the nine-step PROM
// index reduction and three PROM reads, then emits one pixel per cycle while
// the receiver is ready; it takes no new item until its last pixel is
// registered. After reset the block sweeps bitmap, pen and character stores
// to zero and accepts no item until the sweep ends.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_char_video_compositor #(
	parameter int PROM_DEPTH     = 512,
	parameter int VISIBLE_WIDTH  = 256,
	parameter int VISIBLE_HEIGHT = 224
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	// command items
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [12:0] address,
	input  wire logic [7:0]  data,
	// pixel items
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  pixel_x,
	output logic      [7:0]  pixel_y,
	output logic      [7:0]  red,
	output logic      [7:0]  green,
	output logic      [7:0]  blue,
	output logic             visible,
	output logic             last
);

	localparam int PAW = (PROM_DEPTH > 1) ? $clog2(PROM_DEPTH) : 1;
	localparam logic CFG_LAYOUT = 1'b0;
	localparam logic CFG_FLIP   = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_CODE,
		S_PLANE_A,
		S_PLANE_B,
		S_WAIT_MOD,
		S_PROM,
		S_EMIT
	} state_t;

	state_t state_q;
	logic [cvc_pkg::BM_AW-1:0] clr_q;
	logic [12:0]               blk_q;
	logic [2:0]                cur_pen_q;
	logic                      flip_q;
	logic                      layout_select_q;
	logic                      flip_invert_q;
	logic [1:0]                prom_cnt_q;

	// render working registers
	logic [7:0] bits_q, code_q, pa_q, pb_q, prom0_q, prom1_q;
	logic [2:0] pen_q;

	logic         in_fire;
	logic         clearing;
	cvc_pkg::cmd_t cmd;

	// store ports
	logic                        bm_we;
	logic [cvc_pkg::BM_AW-1:0]   bm_waddr;
	logic [7:0]                  bm_wdata, bm_rdata;
	logic                        pen_we;
	logic [cvc_pkg::PEN_AW-1:0]  pen_waddr;
	logic [2:0]                  pen_wdata, pen_rdata;
	logic                        char_we;
	logic [cvc_pkg::CHAR_AW-1:0] char_waddr, char_raddr;
	logic [7:0]                  char_wdata, char_rdata;
	logic                        prom_we;
	logic [PAW-1:0]              prom_raddr;
	logic [7:0]                  prom_rdata;

	logic [PAW-1:0] rem_w [3];
	logic [2:0]     done_w;
	logic           lane_start;

	cvc_pkg::render_job_t job;
	logic                 emit_start;
	logic                 emit_busy;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign clearing = (state_q == S_CLEAR);
	assign cmd      = cvc_pkg::cmd_t'(command);

	// Store write ports: the reset sweep owns them until it ends
	always_comb begin
		bm_we      = clearing || (in_fire && cmd == cvc_pkg::CMD_BITMAP);
		bm_waddr   = clearing ? clr_q : address;
		bm_wdata   = clearing ? 8'd0 : data;
		pen_we     = bm_we;
		pen_waddr  = clearing ? clr_q[cvc_pkg::PEN_AW-1:0] : address[12:3];
		pen_wdata  = clearing ? 3'd0 : cur_pen_q;
		// drop char writes at or above the character RAM size
		char_we    = clearing || (in_fire && cmd == cvc_pkg::CMD_CHAR && !address[12]);
		char_waddr = clearing ? clr_q[cvc_pkg::CHAR_AW-1:0] : address[11:0];
		char_wdata = clearing ? 8'd0 : data;
		prom_we    = in_fire && cmd == cvc_pkg::CMD_PROM && (address < 13'(PROM_DEPTH));
	end

	// Character RAM read address follows the render sequence
	always_comb begin
		case (state_q)
			S_CODE: begin
				char_raddr = {char_rdata[7] ? cvc_pkg::CHAR_PLANE_A : cvc_pkg::CHAR_PLANE_B1,
					char_rdata[6:0], blk_q[2:0]};
			end
			S_PLANE_A: begin
				char_raddr = {cvc_pkg::CHAR_PLANE_B2, code_q[6:0], blk_q[2:0]};
			end
			default: begin
				char_raddr = {cvc_pkg::CHAR_CODE_AREA, blk_q[12:3]};
			end
		endcase
	end

	always_comb begin
		case (prom_cnt_q)
			2'd0:    prom_raddr = rem_w[0];
			2'd1:    prom_raddr = rem_w[1];
			default: prom_raddr = rem_w[2];
		endcase
	end

	cvc_ram #(.WIDTH(8), .DEPTH(cvc_pkg::BITMAP_DEPTH)) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.raddr (blk_q),
		.rdata (bm_rdata)
	);

	cvc_ram #(.WIDTH(3), .DEPTH(cvc_pkg::PEN_DEPTH)) u_pen (
		.clk   (clk),
		.we    (pen_we),
		.waddr (pen_waddr),
		.wdata (pen_wdata),
		.raddr (blk_q[12:3]),
		.rdata (pen_rdata)
	);

	cvc_ram #(.WIDTH(8), .DEPTH(cvc_pkg::CHAR_DEPTH)) u_char (
		.clk   (clk),
		.we    (char_we),
		.waddr (char_waddr),
		.wdata (char_wdata),
		.raddr (char_raddr),
		.rdata (char_rdata)
	);

	cvc_ram #(.WIDTH(8), .DEPTH(PROM_DEPTH)) u_prom (
		.clk   (clk),
		.we    (prom_we),
		.waddr (address[PAW-1:0]),
		.wdata (data),
		.raddr (prom_raddr),
		.rdata (prom_rdata)
	);

	// Reduce the three PROM indexes (character pens 1..3) while the planes load
	assign lane_start = (state_q == S_CODE);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		cvc_mod_lane #(.DEPTH(PROM_DEPTH)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.value  ({char_rdata[7:1], 2'(i + 1)}),
			.rem    (rem_w[i]),
			.done   (done_w[i])
		);
	end

	// The third PROM entry arrives in the cycle the job is handed over
	assign emit_start = (state_q == S_PROM) && (prom_cnt_q == 2'd3);

	always_comb begin
		job.bits    = bits_q;
		job.pa      = pa_q;
		job.pb      = pb_q;
		job.pen     = pen_q;
		job.prio    = (code_q[7:6] == 2'b11);
		job.prom[0] = prom0_q;
		job.prom[1] = prom1_q;
		job.prom[2] = prom_rdata;
		job.col     = ~blk_q[12:8];
		job.row     = blk_q[7:0];
		job.normal  = flip_q ^ flip_invert_q;
		job.layout  = layout_select_q;
	end

	cvc_pixel_serial #(
		.VISIBLE_WIDTH  (VISIBLE_WIDTH),
		.VISIBLE_HEIGHT (VISIBLE_HEIGHT)
	) u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (emit_start),
		.job       (job),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.visible   (visible),
		.last      (last)
	);

	// Configuration registers: written whenever the enable is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_select_q <= 1'b0;
			flip_invert_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LAYOUT: layout_select_q <= cfg_data;
				CFG_FLIP:   flip_invert_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Sequencer: reset sweep, command decode and render steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cur_pen_q  <= '0;
			flip_q     <= 1'b0;
			prom_cnt_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (cmd)
							cvc_pkg::CMD_PEN:    cur_pen_q <= data[2:0];
							cvc_pkg::CMD_FLIP:   flip_q    <= data[0];
							cvc_pkg::CMD_RENDER: state_q   <= S_FETCH;
							default:             ;
						endcase
					end
				end
				S_FETCH: begin
					state_q <= S_CODE;
				end
				S_CODE: begin
					state_q <= S_PLANE_A;
				end
				S_PLANE_A: begin
					// single-plane characters have no second plane read
					state_q <= code_q[7] ? S_PLANE_B : S_WAIT_MOD;
				end
				S_PLANE_B: begin
					state_q <= S_WAIT_MOD;
				end
				S_WAIT_MOD: begin
					if (&done_w) begin
						state_q    <= S_PROM;
						prom_cnt_q <= '0;
					end
				end
				S_PROM: begin
					prom_cnt_q <= prom_cnt_q + 2'd1;
					if (prom_cnt_q == 2'd3) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold until the last pixel sits in the output register
					if (!emit_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Render payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			blk_q <= address;
		end
		case (state_q)
			S_CODE: begin
				bits_q <= bm_rdata;
				pen_q  <= pen_rdata;
				code_q <= char_rdata;
			end
			S_PLANE_A: begin
				if (code_q[7]) begin
					pa_q <= char_rdata;
				end else begin
					pa_q <= 8'd0;
					pb_q <= char_rdata;
				end
			end
			S_PLANE_B: begin
				pb_q <= char_rdata;
			end
			S_PROM: begin
				if (prom_cnt_q == 2'd1) begin
					prom0_q <= prom_rdata;
				end
				if (prom_cnt_q == 2'd2) begin
					prom1_q <= prom_rdata;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cvc_checker.sv =====
// Port-level checker for the video compositor and its bind to the top level.
// Depends on cvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [2:0]  command,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  pixel_x,
	input wire logic [7:0]  pixel_y,
	input wire logic        last
);

	// A stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
		else $error("stalled pixel changed");

	// No command is taken while a render still has pixels to hand over
	a_busy_render: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("command taken during a render");

	// A render is never followed straight away by another command
	a_render_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == cvc_pkg::CMD_RENDER |=> !in_ready)
		else $error("ready stayed high after a render");

	// Pixels of one render come back to back on one row
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && pixel_y == $past(pixel_y))
		else $error("render pixels not contiguous");

endmodule

bind bitmap_char_video_compositor cvc_checker u_cvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y),
	.last      (last)
);

`default_nettype wire

// ===== dv/bitmap_char_video_compositor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_char_video_compositor: drives command items,
// predicts every rendered pixel from its own copy of the video stores and
// checks the pixel items in order. Depends on cvc_pkg and the compositor RTL.

module bitmap_char_video_compositor_tb;

	// Geometry and sizes of the block as instantiated
	localparam int VIS_W        = 256;
	localparam int VIS_H        = 224;
	localparam int PROM_ENTRIES = 512;
	localparam int CODE_AREA    = 1024;

	// Commands 6 and 7 are unused by the block: it must drop them silently
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	// Configuration register indexes
	localparam logic REG_LAYOUT   = 1'b0;
	localparam logic REG_FLIP_INV = 1'b1;

	// Background mix constants of the board
	localparam logic [7:0] BACK_RED = 8'h18;
	localparam logic [7:0] BACK_GB  = 8'h24;
	localparam logic [7:0] BACK_MIX = 8'h31;
	localparam int         STEP3    = 36;
	localparam int         STEP2    = 85;

	// Receiver hold-off long enough for the block to fill up and stall its input
	localparam int HOLD_CYCLES    = 400;
	// Allow well over one render's length before touching registers
	localparam int SETTLE_CYCLES  = 64;
	// Covers the clearing sweep after reset with a wide margin
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 97;

	typedef struct {
		logic [2:0]  cmd;
		logic [12:0] addr;
		logic [7:0]  dat;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       vis;
		logic       lst;
	} pixel_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data  = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [2:0]  command   = '0;
	logic [12:0] address   = '0;
	logic [7:0]  data      = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        visible;
	logic        last;

	always #5 clk = ~clk;

	bitmap_char_video_compositor #(
		.PROM_DEPTH     (PROM_ENTRIES),
		.VISIBLE_WIDTH  (VIS_W),
		.VISIBLE_HEIGHT (VIS_H)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.address   (address),
		.data      (data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.visible   (visible),
		.last      (last)
	);

	// ------------------------------------------------------------------
	// Board copy: the stores and settings as the block should hold them,
	// updated at the edge where each command item is accepted.
	// ------------------------------------------------------------------
	logic [7:0] vid_bitmap [8192];
	logic [2:0] vid_pen    [1024];
	logic [7:0] vid_char   [4096];
	logic [7:0] vid_prom   [PROM_ENTRIES];
	logic [2:0] vid_cur_pen;
	logic       vid_flip;
	logic       set_layout;
	logic       set_flip_inv;

	pixel_t pixels_due [$];
	int     errors = 0;

	// Apply one command to the board copy; a render queues its eight pixels
	function automatic void advance_board(logic [2:0] c, logic [12:0] a, logic [7:0] d);
		logic       normal;
		logic [7:0] bits;
		logic [7:0] pa;
		logic [7:0] pb;
		logic [7:0] code;
		logic [7:0] mix;
		logic [7:0] v;
		logic [2:0] pen;
		logic [9:0] row;
		logic [1:0] cp;
		pixel_t     p;
		pixel_t     back;
		int         xs;
		int         dx;
		int         dy;
		int         k;
		case (c)
			cvc_pkg::CMD_BITMAP: begin
				// the pen tag covers the whole group of eight bytes
				vid_bitmap[a]      = d;
				vid_pen[a[12:3]]   = vid_cur_pen;
			end
			cvc_pkg::CMD_CHAR: begin
				if (a < 13'(cvc_pkg::CHAR_DEPTH))
					vid_char[a[11:0]] = d;
			end
			cvc_pkg::CMD_PROM: begin
				if (a < 13'(PROM_ENTRIES))
					vid_prom[a[8:0]] = d;
			end
			cvc_pkg::CMD_PEN:  vid_cur_pen = d[2:0];
			cvc_pkg::CMD_FLIP: vid_flip    = d[0];
			cvc_pkg::CMD_RENDER: begin
				normal = vid_flip ^ set_flip_inv;
				bits   = vid_bitmap[a];
				pen    = vid_pen[a[12:3]];
				code   = vid_char[{2'b00, a[12:3]}];
				row    = {code[6:0], a[2:0]};
				// two-plane characters take both planes, others only plane B
				if (code[7]) begin
					pa = vid_char[{2'b01, row}];
					pb = vid_char[{2'b11, row}];
				end else begin
					pa = 8'h00;
					pb = vid_char[{2'b10, row}];
				end
				mix    = BACK_MIX + {7'd0, set_layout};
				back   = '0;
				back.r = BACK_RED ^ {mix[6:0], 1'b0};
				back.g = BACK_GB ^ mix;
				back.b = BACK_GB ^ {1'b0, mix[7:1]};
				xs     = int'({~a[12:8], 3'b000});
				for (k = 0; k < 8; k++) begin
					cp = {pb[7], pa[7]};
					p  = back;
					// a set bitmap bit wins over the character only with priority
					if (cp == 2'd0 || (bits[7] && code[7:6] == 2'b11)) begin
						if (bits[7]) begin
							p.r = {8{pen[2]}};
							p.g = {8{pen[1]}};
							p.b = {8{pen[0]}};
						end
					end else begin
						v   = vid_prom[{code[7:1], cp}];
						p.r = 8'(int'({v[4], v[6], v[2]}) * STEP3);
						p.g = 8'(int'({v[5], v[3], v[1]}) * STEP3);
						p.b = 8'(int'({v[7], v[0]}) * STEP2);
					end
					// mirrored rows past the visible height wrap to large values
					dx    = normal ? xs + k : VIS_W - 1 - (xs + k);
					dy    = normal ? int'(a[7:0]) : VIS_H - 1 - int'(a[7:0]);
					p.x   = dx[7:0];
					p.y   = dy[7:0];
					p.vis = (dx >= 0 && dx < VIS_W && dy >= 0 && dy < VIS_H);
					p.lst = (k == 7);
					pixels_due.push_back(p);
					bits = bits << 1;
					pa   = pa << 1;
					pb   = pb << 1;
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning. The planner keeps its own view of the character
	// codes and of which PROM entries hold data, so that no render ever
	// reads a PROM entry that was never loaded.
	// ------------------------------------------------------------------
	cmd_item_t cmds_pending [$];
	logic [7:0] plan_code [CODE_AREA];
	bit         plan_prom_loaded [PROM_ENTRIES];

	function automatic void queue_cmd(logic [2:0] c, logic [12:0] a, logic [7:0] d);
		cmd_item_t it;
		it.cmd  = c;
		it.addr = a;
		it.dat  = d;
		if (c == cvc_pkg::CMD_CHAR && a < 13'(CODE_AREA))
			plan_code[a[9:0]] = d;
		if (c == cvc_pkg::CMD_PROM && a < 13'(PROM_ENTRIES))
			plan_prom_loaded[a[8:0]] = 1'b1;
		cmds_pending.push_back(it);
	endfunction

	// Load any missing PROM entry of the block's colour group, then render
	function automatic void queue_render(logic [12:0] a);
		logic [7:0] code;
		logic [8:0] idx;
		int         j;
		code = plan_code[a[12:3]];
		for (j = 0; j < 4; j++) begin
			idx = {code[7:1], 2'(j)};
			if (!plan_prom_loaded[idx])
				queue_cmd(cvc_pkg::CMD_PROM, 13'(idx), 8'($urandom));
		end
		queue_cmd(cvc_pkg::CMD_RENDER, a, 8'($urandom));
	endfunction

	// Mostly coherent scenes around a drifting window of bitmap bytes: bitmap
	// writes, codes and plane rows for the blocks being rendered, plus noise
	function automatic void queue_random_phase(int n);
		logic [12:0] hot;
		logic [12:0] a;
		logic [7:0]  code;
		logic [9:0]  row;
		int          pick;
		int          i;
		hot = 13'($urandom);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				hot = 13'($urandom);
			a    = ($urandom_range(0, 3) != 0) ? hot + 13'($urandom_range(0, 31))
			                                   : 13'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 34) begin
				queue_render(a);
			end else if (pick < 54) begin
				queue_cmd(cvc_pkg::CMD_BITMAP, a, 8'($urandom));
			end else if (pick < 62) begin
				queue_cmd(cvc_pkg::CMD_CHAR, {3'b000, a[12:3]}, 8'($urandom));
			end else if (pick < 74) begin
				code = plan_code[a[12:3]];
				row  = {code[6:0], a[2:0]};
				queue_cmd(cvc_pkg::CMD_CHAR, {1'b0, 2'($urandom_range(1, 3)), row},
					8'($urandom));
			end else if (pick < 78) begin
				queue_cmd(cvc_pkg::CMD_CHAR, 13'($urandom), 8'($urandom));
			end else if (pick < 86) begin
				queue_cmd(cvc_pkg::CMD_PEN, 13'($urandom), 8'($urandom));
			end else if (pick < 92) begin
				queue_cmd(cvc_pkg::CMD_FLIP, 13'($urandom), 8'($urandom));
			end else if (pick < 97) begin
				queue_cmd(cvc_pkg::CMD_PROM, 13'($urandom), 8'($urandom));
			end else begin
				queue_cmd($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
					13'($urandom), 8'($urandom));
			end
		end
	endfunction

	// Corner cases: field extremes, planes, priority, flip, dropped writes
	function automatic void queue_directed();
		queue_cmd(cvc_pkg::CMD_PROM, 13'h0000, 8'h00);
		queue_cmd(cvc_pkg::CMD_PEN, 13'h0000, 8'hFD);       // pen 5, upper bits ignored
		queue_cmd(cvc_pkg::CMD_BITMAP, 13'h0000, 8'hA5);
		queue_render(13'h0000);                             // plain bitmap over background
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h0800, 8'hF0);      // single-plane row
		queue_render(13'h0000);
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h0000, 8'hC3);      // two planes with priority
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h0618, 8'h3C);
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h0E18, 8'h0F);
		queue_render(13'h0000);
		queue_cmd(cvc_pkg::CMD_FLIP, 13'h0000, 8'h01);
		queue_render(13'h1FFF);                             // bottom row, off screen
		queue_cmd(cvc_pkg::CMD_FLIP, 13'h0000, 8'hFE);
		queue_cmd(cvc_pkg::CMD_PEN, 13'h1FFF, 8'hFF);
		queue_cmd(cvc_pkg::CMD_BITMAP, 13'h1FFF, 8'h81);
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h03FF, 8'hFF);
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h0FFF, 8'hFF);
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h07FF, 8'hAA);
		queue_cmd(cvc_pkg::CMD_CHAR, 13'h1FFF, 8'h00);      // beyond the store: drop
		queue_cmd(cvc_pkg::CMD_PROM, 13'h01FF, 8'hFF);
		queue_cmd(cvc_pkg::CMD_PROM, 13'h0200, 8'h00);      // beyond the PROM: drop
		queue_cmd(cvc_pkg::CMD_PROM, 13'h1FFF, 8'h00);
		queue_cmd(CMD_SPARE_A, 13'h1FFF, 8'hFF);
		queue_cmd(CMD_SPARE_B, 13'h0000, 8'h00);
		queue_render(13'h1FFF);                             // mirrored, last PROM entry
	endfunction

	// ------------------------------------------------------------------
	// Driver: offer queued items, holding each until accepted, with a
	// random wait drawn for every item.
	// ------------------------------------------------------------------
	int        tx_gap_max = 0;
	int        tx_wait    = 0;
	cmd_item_t tx_item;

	always @(posedge clk) begin
		if (in_valid && in_ready)
			advance_board(command, address, data);
		if (!in_valid || in_ready) begin
			if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (cmds_pending.size() != 0) begin
				tx_item = cmds_pending.pop_front();
				command  <= tx_item.cmd;
				address  <= tx_item.addr;
				data     <= tx_item.dat;
				in_valid <= 1'b1;
				tx_wait  = $urandom_range(0, tx_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: accept pixels with random stalls and check them in order.
	// One long hold-off, on request, lets the block back up.
	// ------------------------------------------------------------------
	int     rx_gap_max = 0;
	int     rx_wait    = 0;
	logic   hold_req   = 1'b0;
	logic   hold_done  = 1'b0;
	int     hold_count = 0;
	pixel_t rx_due;
	pixel_t rx_got;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			rx_got = {pixel_x, pixel_y, red, green, blue, visible, last};
			if (pixels_due.size() == 0) begin
				errors++;
				$display("%0t: pixel with nothing expected: x=%0d y=%0d rgb=%02h%02h%02h",
					$time, pixel_x, pixel_y, red, green, blue);
			end else begin
				rx_due = pixels_due.pop_front();
				if (rx_got !== rx_due) begin
					errors++;
					$display("%0t: pixel mismatch: expected x=%0d y=%0d rgb=%02h%02h%02h vis=%0b last=%0b",
						$time, rx_due.x, rx_due.y, rx_due.r, rx_due.g, rx_due.b,
						rx_due.vis, rx_due.lst);
					$display("%0t:                 actual x=%0d y=%0d rgb=%02h%02h%02h vis=%0b last=%0b",
						$time, rx_got.x, rx_got.y, rx_got.r, rx_got.g, rx_got.b,
						rx_got.vis, rx_got.lst);
				end
			end
			rx_wait = $urandom_range(0, rx_gap_max);
		end
		if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_count++;
			if (hold_count >= HOLD_CYCLES)
				hold_done <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run when nothing moves for too long
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("bitmap_char_video_compositor_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing of the run
	// ------------------------------------------------------------------
	task automatic write_reg(logic idx, logic val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LAYOUT)
			set_layout = val;
		else
			set_flip_inv = val;
	endtask

	// Hold until every item is in and every pixel out, then let the pipe empty
	task automatic settle();
		do
			@(negedge clk);
		while (cmds_pending.size() != 0 || in_valid || pixels_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(logic layout, logic flip_inv, int tx_max, int rx_max,
		logic long_hold);
		write_reg(REG_LAYOUT, layout);
		write_reg(REG_FLIP_INV, flip_inv);
		@(negedge clk);
		tx_gap_max = tx_max;
		rx_gap_max = rx_max;
		if (long_hold)
			hold_req = 1'b1;
		queue_random_phase(PHASE_ITEMS);
		settle();
	endtask

	initial begin
		// reset contents of the stores; the PROM has none until loaded
		for (int i = 0; i < 8192; i++)
			vid_bitmap[i] = 8'h00;
		for (int i = 0; i < 1024; i++) begin
			vid_pen[i]   = 3'd0;
			plan_code[i] = 8'h00;
		end
		for (int i = 0; i < 4096; i++)
			vid_char[i] = 8'h00;
		for (int i = 0; i < PROM_ENTRIES; i++) begin
			vid_prom[i]         = 8'h00;
			plan_prom_loaded[i] = 1'b0;
		end
		vid_cur_pen  = 3'd0;
		vid_flip     = 1'b0;
		set_layout   = 1'b0;
		set_flip_inv = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the clearing sweep
		do
			@(negedge clk);
		while (in_ready !== 1'b1);

		// directed corners at the reset settings, light idling
		write_reg(REG_LAYOUT, 1'b0);
		write_reg(REG_FLIP_INV, 1'b0);
		@(negedge clk);
		tx_gap_max = 3;
		rx_gap_max = 3;
		queue_directed();
		settle();

		// random scenes across the register settings and idling profiles
		run_phase(1'b1, 1'b1, 10, 10, 1'b0);
		run_phase(1'b0, 1'b1, 0, 0, 1'b1);
		run_phase(1'b1, 1'b0, 10, 0, 1'b0);
		run_phase(1'($urandom), 1'($urandom), 0, 10, 1'b0);

		if (errors == 0)
			$display("bitmap_char_video_compositor_tb: PASS");
		else
			$display("bitmap_char_video_compositor_tb: FAIL");
		$finish;
	end

endmodule
